### rtl/mp3gp_pkg.sv
`timescale 1ns / 1ps

package mp3gp_pkg;

    localparam int HEAD_BYTES_DEF = 8192;

    localparam int TOTAL_W   = 48;
    localparam int DELAY_W   = 12;
    localparam int SKIP_W    = 14;
    localparam int PLAY_W    = 48;
    localparam int OUTCOME_W = 2;
    localparam int COUNT_W   = 32;
    localparam int DP_W      = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 48;

    localparam int FRAME_SAMPLES = 1152;
    localparam logic [DELAY_W-1:0] DECODER_DELAY_RST = 12'd529;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_TOTAL_FRAMES  = 1'b0;
    localparam cfg_idx_t CFG_DECODER_DELAY = 1'b1;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_ID3    = 3'd1,
        PH_HEADER = 3'd2,
        PH_TAG    = 3'd3,
        PH_EXT    = 3'd4,
        PH_FAIL   = 3'd7
    } phase_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NONE     = 2'd0,
        OUT_COUNT    = 2'd1,
        OUT_GAPLESS  = 2'd2,
        OUT_TOO_LONG = 2'd3
    } outcome_t;

    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] SYNC_FF = 8'hFF;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    // parse state handed to the result pipeline on the last item
    typedef struct packed {
        logic               is_ext;
        logic               ext_ok;
        logic               printable;
        logic [COUNT_W-1:0] stated;
        logic [DP_W-1:0]    delay_pad;
    } snap_t;

    function automatic logic [7:0] tag_char(input logic is_info, input logic [1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            2'd0: c = is_info ? 8'h49 : 8'h58;
            2'd1: c = is_info ? 8'h6E : 8'h69;
            2'd2: c = is_info ? 8'h66 : 8'h6E;
            default: c = is_info ? 8'h6F : 8'h67;
        endcase
        return c;
    endfunction

endpackage

### rtl/mp3gp_byte_if.sv
`timescale 1ns / 1ps

interface mp3gp_byte_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/mp3gp_result_if.sv
`timescale 1ns / 1ps

interface mp3gp_result_if import mp3gp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SKIP_W-1:0]    skip_frames;
    logic [PLAY_W-1:0]    play_frames;
    logic [OUTCOME_W-1:0] outcome;

    modport source (output valid, output skip_frames, output play_frames, output outcome,
                    input ready);
    modport sink (input valid, input skip_frames, input play_frames, input outcome,
                  output ready);
endinterface

### rtl/mp3gp_cfg_if.sv
`timescale 1ns / 1ps

interface mp3gp_cfg_if import mp3gp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mp3gp_parser.sv
`timescale 1ns / 1ps

module mp3gp_parser import mp3gp_pkg::*; #(
    parameter int HEAD_BYTES = HEAD_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output snap_t      snap
);

    localparam int OFF_W = $clog2(HEAD_BYTES + 1);
    localparam int OW    = OFF_W + 1;
    localparam logic [OW-1:0]    OFF_MAX = '1;
    localparam logic [OFF_W-1:0] OFF_END = OFF_W'(HEAD_BYTES);

    logic [OFF_W-1:0]   off_reg, off_next;
    logic [28:0]        id3_reg, id3_next;
    logic [OW-1:0]      frame_start_reg, frame_start_next;
    logic               mpeg1_reg, mpeg1_next;
    logic               mono_reg, mono_next;
    logic [OW-1:0]      tag_start_reg, tag_start_next;
    logic               matched_reg, matched_next;
    logic               info_reg, info_next;
    logic [COUNT_W-1:0] stated_reg, stated_next;
    logic [OW-1:0]      ext_start_reg, ext_start_next;
    logic               printable_reg, printable_next;
    logic [DP_W-1:0]    dp_reg, dp_next;
    phase_t             phase_reg, phase_next;

    always_comb
    begin
        logic [OW-1:0] pos;
        logic [OW-1:0] r;
        logic [27:0]   size;
        logic [28:0]   fs_wide;
        logic [OW-1:0] side;

        off_next         = off_reg;
        id3_next         = id3_reg;
        frame_start_next = frame_start_reg;
        mpeg1_next       = mpeg1_reg;
        mono_next        = mono_reg;
        tag_start_next   = tag_start_reg;
        matched_next     = matched_reg;
        info_next        = info_reg;
        stated_next      = stated_reg;
        ext_start_next   = ext_start_reg;
        printable_next   = printable_reg;
        dp_next          = dp_reg;
        phase_next       = phase_reg;

        pos     = OW'(off_reg);
        r       = '0;
        size    = {id3_reg[20:0], data_byte[6:0]};
        fs_wide = 29'd10 + {1'b0, size} + (id3_reg[28] ? 29'd10 : 29'd0);
        side    = '0;

        if (off_reg < OFF_END)
        begin
            off_next = off_reg + OFF_W'(1);
            unique case (phase_reg)
                PH_START:
                begin
                    if (data_byte == CH_I)
                    begin
                        phase_next = PH_ID3;
                    end
                    else
                    begin
                        frame_start_next = '0;
                        phase_next = (data_byte == SYNC_FF) ? PH_HEADER : PH_FAIL;
                    end
                end
                PH_ID3:
                begin
                    if ((pos == OW'(1) && data_byte != CH_D) ||
                        (pos == OW'(2) && data_byte != CH_3))
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (pos == OW'(5) && data_byte[4])
                    begin
                        id3_next[28] = 1'b1;
                    end
                    else if (pos >= OW'(6) && pos <= OW'(9))
                    begin
                        id3_next = {id3_reg[28], size};
                        if (pos == OW'(9))
                        begin
                            // saturate: a start past the window is never reached
                            frame_start_next = (fs_wide > 29'(OFF_MAX)) ? OFF_MAX
                                                                        : OW'(fs_wide);
                            phase_next = PH_HEADER;
                        end
                    end
                end
                PH_HEADER:
                begin
                    if (pos >= frame_start_reg)
                    begin
                        r = pos - frame_start_reg;
                        if (r == OW'(0))
                        begin
                            if (data_byte != SYNC_FF)
                                phase_next = PH_FAIL;
                        end
                        else if (r == OW'(1))
                        begin
                            if (data_byte[7:5] != 3'b111)
                                phase_next = PH_FAIL;
                            else if (data_byte[4:3] == 2'b11)
                                mpeg1_next = 1'b1;
                        end
                        else if (r == OW'(3))
                        begin
                            mono_next = mono_reg | (data_byte[7:6] == 2'b11);
                            if (mpeg1_reg)
                                side = mono_next ? OW'(17) : OW'(32);
                            else
                                side = mono_next ? OW'(9) : OW'(17);
                            tag_start_next = frame_start_reg + OW'(4) + side;
                            phase_next = PH_TAG;
                        end
                    end
                end
                PH_TAG:
                begin
                    if (pos >= tag_start_reg)
                    begin
                        r = pos - tag_start_reg;
                        if (r == OW'(0))
                        begin
                            info_next    = (data_byte == CH_I);
                            matched_next = (data_byte == CH_X) || (data_byte == CH_I);
                        end
                        else if (r < OW'(4))
                        begin
                            if (data_byte != tag_char(info_reg, r[1:0]))
                                matched_next = 1'b0;
                        end
                        else if (r == OW'(7))
                        begin
                            ext_start_next = tag_start_reg + OW'(8)
                                + (data_byte[0] ? OW'(4) : OW'(0))
                                + (data_byte[1] ? OW'(4) : OW'(0))
                                + (data_byte[2] ? OW'(100) : OW'(0))
                                + (data_byte[3] ? OW'(4) : OW'(0));
                            if (!data_byte[0])
                                phase_next = PH_EXT;
                        end
                        else if (r >= OW'(8) && r <= OW'(11))
                        begin
                            stated_next = {stated_reg[COUNT_W-9:0], data_byte};
                            if (r == OW'(11))
                                phase_next = PH_EXT;
                        end
                        if (r == OW'(3) && !matched_next)
                            phase_next = PH_FAIL;
                    end
                end
                PH_EXT:
                begin
                    if (pos >= ext_start_reg)
                    begin
                        r = pos - ext_start_reg;
                        if (r < OW'(4))
                        begin
                            if (data_byte < PRINT_LO || data_byte > PRINT_HI)
                                printable_next = 1'b0;
                        end
                        else if (r >= OW'(21) && r <= OW'(23))
                        begin
                            dp_next = {dp_reg[DP_W-9:0], data_byte};
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        snap.is_ext    = (phase_next == PH_EXT);
        snap.ext_ok    = ({1'b0, ext_start_next} + (OW+1)'(24)) <= (OW+1)'(off_next);
        snap.printable = printable_next;
        snap.stated    = stated_next;
        snap.delay_pad = dp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg         <= '0;
            id3_reg         <= '0;
            frame_start_reg <= '0;
            mpeg1_reg       <= 1'b0;
            mono_reg        <= 1'b0;
            tag_start_reg   <= '0;
            matched_reg     <= 1'b0;
            info_reg        <= 1'b0;
            stated_reg      <= '0;
            ext_start_reg   <= '0;
            printable_reg   <= 1'b1;
            dp_reg          <= '0;
            phase_reg       <= PH_START;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                // new file starts with the next item
                off_reg         <= '0;
                id3_reg         <= '0;
                frame_start_reg <= '0;
                mpeg1_reg       <= 1'b0;
                mono_reg        <= 1'b0;
                tag_start_reg   <= '0;
                matched_reg     <= 1'b0;
                info_reg        <= 1'b0;
                stated_reg      <= '0;
                ext_start_reg   <= '0;
                printable_reg   <= 1'b1;
                dp_reg          <= '0;
                phase_reg       <= PH_START;
            end
            else
            begin
                off_reg         <= off_next;
                id3_reg         <= id3_next;
                frame_start_reg <= frame_start_next;
                mpeg1_reg       <= mpeg1_next;
                mono_reg        <= mono_next;
                tag_start_reg   <= tag_start_next;
                matched_reg     <= matched_next;
                info_reg        <= info_next;
                stated_reg      <= stated_next;
                ext_start_reg   <= ext_start_next;
                printable_reg   <= printable_next;
                dp_reg          <= dp_next;
                phase_reg       <= phase_next;
            end
        end
    end

endmodule

### rtl/mp3gp_finish.sv
`timescale 1ns / 1ps

module mp3gp_finish import mp3gp_pkg::*; (
    input  logic                 clk,
    input  logic                 load_snap,
    input  logic                 load_dec,
    input  logic                 load_play,
    input  logic                 load_out,
    input  snap_t                snap,
    input  logic [TOTAL_W-1:0]   total_frames,
    input  logic [DELAY_W-1:0]   decoder_delay,
    output logic [SKIP_W-1:0]    skip_frames,
    output logic [PLAY_W-1:0]    play_frames,
    output logic [OUTCOME_W-1:0] outcome
);

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_COUNT = 2'd1,
        CLS_FULL  = 2'd2
    } cls_t;

    localparam logic [TOTAL_W-1:0] FS48 = TOTAL_W'(FRAME_SAMPLES);

    snap_t                snap_reg;

    logic [TOTAL_W-1:0]   decoded3_reg, decoded3_next;
    logic [DELAY_W:0]     dp3_reg, dp3_next;
    logic [DELAY_W-1:0]   delay3_reg;
    cls_t                 cls3_reg, cls3_next;

    logic [TOTAL_W-1:0]   decoded4_reg;
    logic [TOTAL_W-1:0]   play4_reg, play4_next;
    logic [SKIP_W-1:0]    skip4_reg, skip4_next;
    logic                 too_long4_reg, too_long4_next;
    cls_t                 cls4_reg;

    logic [SKIP_W-1:0]    skip_reg, skip_next;
    logic [PLAY_W-1:0]    play_reg, play_next;
    logic [OUTCOME_W-1:0] outcome_reg, outcome_next;

    always_comb
    begin
        logic [TOTAL_W-1:0] stated_x;
        logic [TOTAL_W-1:0] total_less;
        logic               full_ok;

        // count * 1152 = count * 1024 + count * 128
        stated_x   = (TOTAL_W'(snap_reg.stated) << 10) + (TOTAL_W'(snap_reg.stated) << 7);
        total_less = (total_frames > FS48) ? total_frames - FS48 : '0;
        decoded3_next = (snap_reg.stated != '0) ? stated_x : total_less;
        dp3_next = (DELAY_W+1)'(snap_reg.delay_pad[DP_W-1:DELAY_W])
                 + (DELAY_W+1)'(snap_reg.delay_pad[DELAY_W-1:0]);
        full_ok = snap_reg.ext_ok && snap_reg.printable;
        if (snap_reg.is_ext && full_ok)
            cls3_next = CLS_FULL;
        else if (snap_reg.is_ext && snap_reg.stated != '0)
            cls3_next = CLS_COUNT;
        else
            cls3_next = CLS_NONE;
    end

    always_comb
    begin
        too_long4_next = decoded3_reg <= TOTAL_W'(dp3_reg);
        play4_next     = decoded3_reg - TOTAL_W'(dp3_reg);
        skip4_next     = SKIP_W'(FRAME_SAMPLES) + SKIP_W'(delay3_reg) + SKIP_W'(decoder_delay);
    end

    always_comb
    begin
        logic [TOTAL_W:0]   sum;
        logic [TOTAL_W-1:0] clamp;

        sum   = (TOTAL_W+1)'(skip4_reg) + (TOTAL_W+1)'(play4_reg);
        clamp = (total_frames > TOTAL_W'(skip4_reg)) ? total_frames - TOTAL_W'(skip4_reg)
                                                     : '0;
        skip_next    = '0;
        play_next    = total_frames;
        outcome_next = OUT_NONE;
        case (cls4_reg)
            CLS_FULL:
            begin
                if (too_long4_reg)
                begin
                    outcome_next = OUT_TOO_LONG;
                end
                else
                begin
                    skip_next    = skip4_reg;
                    play_next    = (sum > (TOTAL_W+1)'(total_frames)) ? clamp : play4_reg;
                    outcome_next = OUT_GAPLESS;
                end
            end
            CLS_COUNT:
            begin
                skip_next    = SKIP_W'(FRAME_SAMPLES);
                play_next    = decoded4_reg;
                outcome_next = OUT_COUNT;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_snap)
            snap_reg <= snap;
        if (load_dec)
        begin
            decoded3_reg <= decoded3_next;
            dp3_reg      <= dp3_next;
            delay3_reg   <= snap_reg.delay_pad[DP_W-1:DELAY_W];
            cls3_reg     <= cls3_next;
        end
        if (load_play)
        begin
            decoded4_reg  <= decoded3_reg;
            play4_reg     <= play4_next;
            skip4_reg     <= skip4_next;
            too_long4_reg <= too_long4_next;
            cls4_reg      <= cls3_reg;
        end
        if (load_out)
        begin
            skip_reg    <= skip_next;
            play_reg    <= play_next;
            outcome_reg <= outcome_next;
        end
    end

    assign skip_frames = skip_reg;
    assign play_frames = play_reg;
    assign outcome     = outcome_reg;

endmodule

### rtl/mp3_gapless_header_parser_unit.sv
`timescale 1ns / 1ps
// channel  dir  fields                                  accepted when
// bytes    in   data_byte[7:0], last_byte               valid && ready
// result   out  skip_frames[13:0], play_frames[47:0],   valid && ready
//               outcome[1:0]
// cfg      in   index[0], data[47:0]                    valid (ready tied high)
//
// One byte item per cycle. The parse state updates in the cycle after an item
// is taken; a last item's result passes the registered snapshot, decode,
// play/skip and clamp stages into the output register. Async active-low reset
// clears parse state and pipeline valids; total_frames resets to 0,
// decoder_delay to 529. A stalled result holds in the output and intermediate
// stages while bytes keep flowing until a last item finds the pipeline full.

module mp3_gapless_header_parser_unit import mp3gp_pkg::*; #(
    parameter int HEAD_BYTES = HEAD_BYTES_DEF
) (
    input logic           clk,
    input logic           rst_n,
    mp3gp_byte_if.sink    bytes,
    mp3gp_result_if.source result,
    mp3gp_cfg_if.sink     cfg
);

    logic [TOTAL_W-1:0] total_frames_reg;
    logic [DELAY_W-1:0] decoder_delay_reg;

    logic       v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic [7:0] byte1_reg;
    logic       last1_reg;

    logic free_o, free4, free3, free2, free1;
    logic adv4, adv3, adv2, take1, load2;
    snap_t snap;

    assign free_o = !vo_reg || result.ready;
    assign adv4   = v4_reg && free_o;
    assign free4  = !v4_reg || free_o;
    assign adv3   = v3_reg && free4;
    assign free3  = !v3_reg || free4;
    assign adv2   = v2_reg && free3;
    assign free2  = !v2_reg || free3;
    assign take1  = v1_reg && (!last1_reg || free2);
    assign free1  = !v1_reg || take1;
    assign load2  = take1 && last1_reg;

    assign bytes.ready  = free1;
    assign result.valid = vo_reg;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= (bytes.valid && free1) || (v1_reg && !take1);
            v2_reg <= load2 || (v2_reg && !adv2);
            v3_reg <= adv2 || (v3_reg && !adv3);
            v4_reg <= adv3 || (v4_reg && !adv4);
            vo_reg <= adv4 || (vo_reg && !result.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && free1)
        begin
            byte1_reg <= bytes.data_byte;
            last1_reg <= bytes.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_frames_reg  <= '0;
            decoder_delay_reg <= DECODER_DELAY_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TOTAL_FRAMES:  total_frames_reg  <= cfg.data[TOTAL_W-1:0];
                CFG_DECODER_DELAY: decoder_delay_reg <= cfg.data[DELAY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mp3gp_parser #(
        .HEAD_BYTES (HEAD_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take1),
        .data_byte (byte1_reg),
        .last_byte (last1_reg),
        .snap      (snap)
    );

    mp3gp_finish u_finish (
        .clk           (clk),
        .load_snap     (load2),
        .load_dec      (adv2),
        .load_play     (adv3),
        .load_out      (adv4),
        .snap          (snap),
        .total_frames  (total_frames_reg),
        .decoder_delay (decoder_delay_reg),
        .skip_frames   (result.skip_frames),
        .play_frames   (result.play_frames),
        .outcome       (result.outcome)
    );

endmodule
